### src/mvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvt_pkg
// shared types and constants of the 4x4 matrix vector transform core
// ----------------------------------------------------------------------------
package mvt_pkg;

   localparam int NumRegs       = 8;
   localparam int RegAddrWidth  = 3;
   localparam int CsrIndexWidth = 4;
   localparam int RegWidth      = 64;
   localparam int DataWidth     = 32;
   localparam int NumComps      = 4;
   localparam int NumStages     = 4;
   localparam int FracBits      = 16;

   localparam int ProdWidth = 2 * DataWidth;
   localparam int PairWidth = ProdWidth + 1;
   localparam int SumWidth  = ProdWidth + 2;

   // register indexes
   localparam logic [RegAddrWidth-1:0] RegRow0Cols01 = 3'd0;
   localparam logic [RegAddrWidth-1:0] RegRow0Cols23 = 3'd1;
   localparam logic [RegAddrWidth-1:0] RegRow1Cols01 = 3'd2;
   localparam logic [RegAddrWidth-1:0] RegRow1Cols23 = 3'd3;
   localparam logic [RegAddrWidth-1:0] RegRow2Cols01 = 3'd4;
   localparam logic [RegAddrWidth-1:0] RegRow2Cols23 = 3'd5;
   localparam logic [RegAddrWidth-1:0] RegRow3Cols01 = 3'd6;
   localparam logic [RegAddrWidth-1:0] RegRow3Cols23 = 3'd7;

   // identity matrix, one in Q16.16 on the diagonal
   localparam logic [RegWidth-1:0] RegResetValues [NumRegs] = '{
      64'h0000_0000_0001_0000, 64'h0,
      64'h0001_0000_0000_0000, 64'h0,
      64'h0,                   64'h0000_0000_0001_0000,
      64'h0,                   64'h0001_0000_0000_0000
   };

   localparam logic [DataWidth-1:0] SatMax = 32'h7FFF_FFFF;
   localparam logic [DataWidth-1:0] SatMin = 32'h8000_0000;

   typedef struct packed {
      logic [NumStages-1:0] load;
   } stage_ctrl_type;

endpackage
`default_nettype wire

### src/matrix_vector_transform_4x4_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4_core
// 4x4 matrix times homogeneous vector, signed Q16.16, saturating
// ----------------------------------------------------------------------------
// usage
//   csr channel: eight 64 bit matrix registers, two coefficients each (low
//   half even column, high half odd column); csr_ready is always high and
//   writes to an index of 8 or more are dropped. write only while idle
//   req channel: one beat carries an input vector x, y, z, w
//   rsp channel: one beat carries the result vector, row i dot input
// pipeline: four registered stages from an accepted req beat to rsp_valid
//   (multiply, pair add, final add, shift and saturate)
// throughput: one vector per cycle while rsp_stall is low, set by the 16
//   parallel 32x32 multipliers in the first stage
// reset: pipeline empties, matrix returns to identity
// stall: each stage holds while its successor is full and stalled, so
//   bubbles collapse; req_stall rises only when all four stages are full
//   and rsp_stall is high
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4_core (
   input  wire                                  clock,
   input  wire                                  reset,
   // configuration
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [mvt_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire  [mvt_pkg::RegWidth-1:0]         csr_data,
   // input vectors
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire logic signed [mvt_pkg::DataWidth-1:0] req_vec_x,
   input  wire logic signed [mvt_pkg::DataWidth-1:0] req_vec_y,
   input  wire logic signed [mvt_pkg::DataWidth-1:0] req_vec_z,
   input  wire logic signed [mvt_pkg::DataWidth-1:0] req_vec_w,
   // result vectors
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic signed [mvt_pkg::DataWidth-1:0] rsp_out_x,
   output logic signed [mvt_pkg::DataWidth-1:0] rsp_out_y,
   output logic signed [mvt_pkg::DataWidth-1:0] rsp_out_z,
   output logic signed [mvt_pkg::DataWidth-1:0] rsp_out_w
);

   // matrix registers
   logic [mvt_pkg::RegWidth-1:0] mat_ff [mvt_pkg::NumRegs];

   // stage valid bits and per-stage ready
   logic [mvt_pkg::NumStages-1:0] valid_ff, valid_in;
   logic [mvt_pkg::NumStages-1:0] ready;
   mvt_pkg::stage_ctrl_type       ctrl;

   logic signed [mvt_pkg::DataWidth-1:0] vec  [mvt_pkg::NumComps];
   logic signed [mvt_pkg::DataWidth-1:0] coef [mvt_pkg::NumComps][mvt_pkg::NumComps];
   logic        [mvt_pkg::DataWidth-1:0] row_result [mvt_pkg::NumComps];
   logic [mvt_pkg::RegAddrWidth-1:0]     reg_even [mvt_pkg::NumComps];
   logic [mvt_pkg::RegAddrWidth-1:0]     reg_odd  [mvt_pkg::NumComps];

   // config writes, always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= mvt_pkg::RegResetValues;
      end else if (csr_valid && csr_index < mvt_pkg::CsrIndexWidth'(mvt_pkg::NumRegs)) begin
         mat_ff[csr_index[mvt_pkg::RegAddrWidth-1:0]] <= csr_data;
      end
   end

   // which registers hold each row
   assign reg_even[0] = mvt_pkg::RegRow0Cols01;
   assign reg_odd[0]  = mvt_pkg::RegRow0Cols23;
   assign reg_even[1] = mvt_pkg::RegRow1Cols01;
   assign reg_odd[1]  = mvt_pkg::RegRow1Cols23;
   assign reg_even[2] = mvt_pkg::RegRow2Cols01;
   assign reg_odd[2]  = mvt_pkg::RegRow2Cols23;
   assign reg_even[3] = mvt_pkg::RegRow3Cols01;
   assign reg_odd[3]  = mvt_pkg::RegRow3Cols23;

   // unpack coefficients
   always_comb begin
      for (int r = 0; r < mvt_pkg::NumComps; r++) begin
         coef[r][0] = mat_ff[reg_even[r]][mvt_pkg::DataWidth-1:0];
         coef[r][1] = mat_ff[reg_even[r]][mvt_pkg::RegWidth-1:mvt_pkg::DataWidth];
         coef[r][2] = mat_ff[reg_odd[r]][mvt_pkg::DataWidth-1:0];
         coef[r][3] = mat_ff[reg_odd[r]][mvt_pkg::RegWidth-1:mvt_pkg::DataWidth];
      end
   end

   assign vec[0] = req_vec_x;
   assign vec[1] = req_vec_y;
   assign vec[2] = req_vec_z;
   assign vec[3] = req_vec_w;

   // ready ripples back from the output; an empty stage can always load
   always_comb begin
      ready[mvt_pkg::NumStages-1] = !valid_ff[mvt_pkg::NumStages-1] || !rsp_stall;
      for (int k = mvt_pkg::NumStages - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   assign ctrl.load = ready;

   always_comb begin
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < mvt_pkg::NumStages; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ready[0];

   // one pipeline per matrix row
   for (genvar r = 0; r < mvt_pkg::NumComps; r++) begin : g_row
      mvt_row_pipe u_row (
         .clock  (clock),
         .ctrl   (ctrl),
         .coef   (coef[r]),
         .vec    (vec),
         .result (row_result[r])
      );
   end

   assign rsp_valid = valid_ff[mvt_pkg::NumStages-1];
   assign rsp_out_x = row_result[0];
   assign rsp_out_y = row_result[1];
   assign rsp_out_z = row_result[2];
   assign rsp_out_w = row_result[3];

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // input only stalls when every stage is full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("req_stall with a free pipeline stage");

   // an accepted beat lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted beat lost at pipeline entry");

   // a full output stage that is stalled keeps the stage behind it full too
   a_hold_chain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && valid_ff[mvt_pkg::NumStages-2])
         |=> (rsp_valid && valid_ff[mvt_pkg::NumStages-2]))
      else $error("beat dropped while output stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

### src/mvt_row_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvt_row_pipe
// four stage dot product of one matrix row with the input vector
// ----------------------------------------------------------------------------
module mvt_row_pipe (
   input  wire                                  clock,
   input  wire mvt_pkg::stage_ctrl_type         ctrl,
   input  wire logic signed [mvt_pkg::DataWidth-1:0] coef [mvt_pkg::NumComps],
   input  wire logic signed [mvt_pkg::DataWidth-1:0] vec  [mvt_pkg::NumComps],
   output logic         [mvt_pkg::DataWidth-1:0] result
);

   logic signed [mvt_pkg::ProdWidth-1:0] prod_ff [mvt_pkg::NumComps];
   logic signed [mvt_pkg::ProdWidth-1:0] prod_in [mvt_pkg::NumComps];
   logic signed [mvt_pkg::PairWidth-1:0] pair_lo_ff, pair_hi_ff, pair_lo_in, pair_hi_in;
   logic signed [mvt_pkg::SumWidth-1:0]  sum_ff, sum_in;
   logic        [mvt_pkg::DataWidth-1:0] sat_ff, sat_in;
   logic                                 fits;

   // stage 1: exact Q32.32 products
   always_comb begin
      for (int i = 0; i < mvt_pkg::NumComps; i++) begin
         prod_in[i] = mvt_pkg::ProdWidth'(coef[i]) * mvt_pkg::ProdWidth'(vec[i]);
      end
   end

   // stage 2 and 3: exact adder tree
   assign pair_lo_in = mvt_pkg::PairWidth'(prod_ff[0]) + mvt_pkg::PairWidth'(prod_ff[1]);
   assign pair_hi_in = mvt_pkg::PairWidth'(prod_ff[2]) + mvt_pkg::PairWidth'(prod_ff[3]);
   assign sum_in     = mvt_pkg::SumWidth'(pair_lo_ff) + mvt_pkg::SumWidth'(pair_hi_ff);

   // stage 4: floor shift by the fraction bits, then saturate
   assign fits = (sum_ff[mvt_pkg::SumWidth-1 -: (mvt_pkg::SumWidth - mvt_pkg::FracBits
                                                  - mvt_pkg::DataWidth + 1)] == '0)
              || (sum_ff[mvt_pkg::SumWidth-1 -: (mvt_pkg::SumWidth - mvt_pkg::FracBits
                                                  - mvt_pkg::DataWidth + 1)] == '1);

   always_comb begin
      if (fits) begin
         sat_in = sum_ff[mvt_pkg::FracBits +: mvt_pkg::DataWidth];
      end else if (sum_ff[mvt_pkg::SumWidth-1]) begin
         sat_in = mvt_pkg::SatMin;
      end else begin
         sat_in = mvt_pkg::SatMax;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         prod_ff <= prod_in;
      end
      if (ctrl.load[1]) begin
         pair_lo_ff <= pair_lo_in;
         pair_hi_ff <= pair_hi_in;
      end
      if (ctrl.load[2]) begin
         sum_ff <= sum_in;
      end
      if (ctrl.load[3]) begin
         sat_ff <= sat_in;
      end
   end

   assign result = sat_ff;

endmodule
`default_nettype wire

### test/tb_matrix_vector_transform_4x4_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_vector_transform_4x4_core
// self-checking bench for the 4x4 Q16.16 transform core. a queue-fed driver
// offers vertex beats with random gaps, a monitor stalls at random and
// compares every result beat against a local predictor that forms the
// exact dot products, floors and saturates. the matrix starts as identity and is
// reloaded between phases while the pipe is empty: extreme and tiny coefficients,
// cancelling rows, then random matrices with random vertex streams
// ----------------------------------------------------------------------------
module tb_matrix_vector_transform_4x4_core;

   localparam int ClockPeriod   = 12;
   localparam int ResetCycles   = 12;
   localparam int MaxGap        = 5;
   localparam int LongHold      = 150;
   localparam int DrainCycles   = 8;
   localparam int WatchdogLimit = 2000;
   localparam int RandomPhases  = 7;
   localparam int ItemsPerPhase = 250;
   localparam int BurstPeriod   = 40;

   // q16.16 values used by the directed part
   localparam logic [mvt_pkg::DataWidth-1:0] QOne      = 32'h0001_0000;
   localparam logic [mvt_pkg::DataWidth-1:0] QMinusOne = 32'hFFFF_0000;
   localparam logic [mvt_pkg::DataWidth-1:0] QLsb      = 32'h0000_0001;
   localparam logic [mvt_pkg::DataWidth-1:0] QMinusLsb = 32'hFFFF_FFFF;
   localparam logic [mvt_pkg::DataWidth-1:0] QHalf     = 32'h0000_8000;
   localparam logic [mvt_pkg::DataWidth-1:0] QMinusOneHalf = 32'hFFFE_8000;

   // saturation bounds at the width of the exact sum
   localparam logic signed [mvt_pkg::SumWidth-1:0] SumMax = 66'sd2147483647;
   localparam logic signed [mvt_pkg::SumWidth-1:0] SumMin = -66'sd2147483648;

   typedef struct packed {
      logic signed [mvt_pkg::DataWidth-1:0] x;
      logic signed [mvt_pkg::DataWidth-1:0] y;
      logic signed [mvt_pkg::DataWidth-1:0] z;
      logic signed [mvt_pkg::DataWidth-1:0] w;
   } vertex_type;

   typedef logic [mvt_pkg::RegWidth-1:0] matrix_type [mvt_pkg::NumRegs];

   // dut ports, all inputs known from time zero
   logic                                 clock     = 1'b0;
   logic                                 reset     = 1'b1;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [mvt_pkg::CsrIndexWidth-1:0]    csr_index = '0;
   logic [mvt_pkg::RegWidth-1:0]         csr_data  = '0;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic signed [mvt_pkg::DataWidth-1:0] req_vec_x = '0;
   logic signed [mvt_pkg::DataWidth-1:0] req_vec_y = '0;
   logic signed [mvt_pkg::DataWidth-1:0] req_vec_z = '0;
   logic signed [mvt_pkg::DataWidth-1:0] req_vec_w = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b1;
   logic signed [mvt_pkg::DataWidth-1:0] rsp_out_x;
   logic signed [mvt_pkg::DataWidth-1:0] rsp_out_y;
   logic signed [mvt_pkg::DataWidth-1:0] rsp_out_z;
   logic signed [mvt_pkg::DataWidth-1:0] rsp_out_w;

   // bench state
   matrix_type  matrix_regs;
   vertex_type  vertex_queue [$];
   vertex_type  expected_vertices [$];
   int unsigned error_count  = 0;
   int unsigned tx_gap       = 0;
   int unsigned tx_sent      = 0;
   bit          tx_burst     = 1'b0;
   int unsigned rx_hold      = 0;
   int unsigned rx_beats     = 0;
   bit          rx_burst     = 1'b0;
   int unsigned quiet_cycles = 0;

   matrix_vector_transform_4x4_core i_dut (
      .clock,
      .reset,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_data,
      .req_valid,
      .req_stall,
      .req_vec_x,
      .req_vec_y,
      .req_vec_z,
      .req_vec_w,
      .rsp_valid,
      .rsp_stall,
      .rsp_out_x,
      .rsp_out_y,
      .rsp_out_z,
      .rsp_out_w
   );

   initial begin
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   // exact q32.32 products summed at full width, floor shift, then clamp
   function automatic logic signed [mvt_pkg::DataWidth-1:0] row_dot(int row, vertex_type v);
      logic signed [mvt_pkg::DataWidth-1:0] comp [mvt_pkg::NumComps];
      logic signed [mvt_pkg::DataWidth-1:0] coeff;
      logic signed [mvt_pkg::SumWidth-1:0]  acc;
      comp = '{v.x, v.y, v.z, v.w};
      acc  = '0;
      for (int col = 0; col < mvt_pkg::NumComps; col++) begin
         // low half holds the even column, high half the odd one
         coeff = matrix_regs[2 * row + col / 2]
                            [mvt_pkg::DataWidth * (col % 2) +: mvt_pkg::DataWidth];
         acc += mvt_pkg::SumWidth'(coeff) * mvt_pkg::SumWidth'(comp[col]);
      end
      acc = acc >>> mvt_pkg::FracBits;
      if (acc > SumMax) return mvt_pkg::SatMax;
      if (acc < SumMin) return mvt_pkg::SatMin;
      return acc[mvt_pkg::DataWidth-1:0];
   endfunction

   function automatic vertex_type transform_vertex(vertex_type v);
      vertex_type r;
      r.x = row_dot(0, v);
      r.y = row_dot(1, v);
      r.z = row_dot(2, v);
      r.w = row_dot(3, v);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // mismatch reporting
   // ------------------------------------------------------------------------

   task automatic report_mismatch(string msg);
      error_count++;
      $display("mismatch: %s", msg);
   endtask

   task automatic check_component(string name, logic [mvt_pkg::DataWidth-1:0] got,
                                  logic [mvt_pkg::DataWidth-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("beat %0d out_%s got %h expected %h",
                                   rx_beats, name, got, want));
   endtask

   // ------------------------------------------------------------------------
   // req driver: pops the vertex queue, predicts on every accepted beat
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      vertex_type next_vertex;
      bit         taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && !req_stall;
         if (taken)
            expected_vertices.push_back(
               transform_vertex({req_vec_x, req_vec_y, req_vec_z, req_vec_w}));
         // a stalled beat holds its payload; valid drops for a gap or an empty queue
         if (!req_valid || taken) begin
            if (tx_gap != 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (vertex_queue.size() != 0) begin
               next_vertex = vertex_queue.pop_front();
               req_vec_x <= next_vertex.x;
               req_vec_y <= next_vertex.y;
               req_vec_z <= next_vertex.z;
               req_vec_w <= next_vertex.w;
               req_valid <= 1'b1;
               tx_sent++;
               // now and then a run of back to back beats
               if (tx_sent % BurstPeriod == 0) tx_burst = ($urandom_range(0, 3) == 0);
               tx_gap = tx_burst ? 0 : $urandom_range(0, MaxGap);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // rsp monitor: random stall per beat, plus a long hold now and then so
   // the pipe fills and req_stall has to rise
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      vertex_type want;
      bit         taken;
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         taken = rsp_valid && !rsp_stall;
         if (taken) begin
            if (expected_vertices.size() == 0) begin
               report_mismatch($sformatf("beat %0d arrived with nothing expected",
                                         rx_beats));
            end else begin
               want = expected_vertices.pop_front();
               check_component("x", rsp_out_x, want.x);
               check_component("y", rsp_out_y, want.y);
               check_component("z", rsp_out_z, want.z);
               check_component("w", rsp_out_w, want.w);
            end
            rx_beats++;
            if (rx_beats % BurstPeriod == 0) rx_burst = ($urandom_range(0, 3) == 0);
            if (rx_beats % 600 == 300) rx_hold = LongHold;
            else rx_hold = rx_burst ? 0 : $urandom_range(0, MaxGap);
         end else if (rx_hold != 0) begin
            rx_hold--;
         end
         rsp_stall <= (rx_hold != 0);
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: too long without any beat on any channel ends the run
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WatchdogLimit) begin
         $display("watchdog: no beat for %0d cycles", WatchdogLimit);
         $display("tb_matrix_vector_transform_4x4_core failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   function automatic vertex_type make_vertex(logic [mvt_pkg::DataWidth-1:0] x,
                                              logic [mvt_pkg::DataWidth-1:0] y,
                                              logic [mvt_pkg::DataWidth-1:0] z,
                                              logic [mvt_pkg::DataWidth-1:0] w);
      return {x, y, z, w};
   endfunction

   // every register gets the same even and odd coefficient
   function automatic matrix_type pattern_matrix(logic [mvt_pkg::DataWidth-1:0] even,
                                                 logic [mvt_pkg::DataWidth-1:0] odd);
      matrix_type m;
      foreach (m[i]) m[i] = {odd, even};
      return m;
   endfunction

   // extremes, unit values, small values within +-2.0, or any bit pattern
   function automatic logic [mvt_pkg::DataWidth-1:0] rand_coeff();
      case ($urandom_range(0, 7))
         0:       return mvt_pkg::SatMax;
         1:       return mvt_pkg::SatMin;
         2:       return '0;
         3:       return QOne;
         4:       return QMinusOne;
         5, 6:    return mvt_pkg::DataWidth'($urandom_range(0, 32'h0003_FFFF))
                         - 32'h0002_0000;
         default: return $urandom();
      endcase
   endfunction

   // small values within +-1024.0 keep most sums clear of saturation
   function automatic logic [mvt_pkg::DataWidth-1:0] rand_component();
      case ($urandom_range(0, 9))
         0:       return mvt_pkg::SatMax;
         1:       return mvt_pkg::SatMin;
         2:       return '0;
         3:       return QMinusLsb;
         4, 5:    return mvt_pkg::DataWidth'($urandom_range(0, 32'h07FF_FFFF))
                         - 32'h0400_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic vertex_type rand_vertex();
      return {rand_component(), rand_component(), rand_component(), rand_component()};
   endfunction

   // called right after a rising edge; leaves csr_valid high for the caller
   task automatic csr_write(logic [mvt_pkg::CsrIndexWidth-1:0] index,
                            logic [mvt_pkg::RegWidth-1:0] data);
      bit ready_seen;
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do begin
         @(negedge clock);
         ready_seen = csr_ready;
         @(posedge clock);
      end while (!ready_seen);
      // writes past the last register are dropped
      if (index < mvt_pkg::NumRegs) matrix_regs[index[mvt_pkg::RegAddrWidth-1:0]] = data;
   endtask

   // all eight registers, optionally one write to an unused index at the end
   task automatic load_matrix(matrix_type m, bit with_unused);
      for (int i = 0; i < mvt_pkg::NumRegs; i++)
         csr_write(mvt_pkg::CsrIndexWidth'(i), m[i]);
      if (with_unused)
         csr_write(mvt_pkg::CsrIndexWidth'($urandom_range(mvt_pkg::NumRegs,
                                                          2 ** mvt_pkg::CsrIndexWidth - 1)),
                   {$urandom(), $urandom()});
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // wait for the sender to run dry and every result to come back
   task automatic wait_idle();
      @(negedge clock);
      while (vertex_queue.size() != 0 || req_valid || expected_vertices.size() != 0)
         @(negedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      matrix_type m;
      foreach (matrix_regs[i]) matrix_regs[i] = mvt_pkg::RegResetValues[i];
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // identity out of reset
      vertex_queue.push_back(make_vertex('0, '0, '0, '0));
      vertex_queue.push_back(make_vertex(mvt_pkg::SatMax, mvt_pkg::SatMax,
                                         mvt_pkg::SatMax, mvt_pkg::SatMax));
      vertex_queue.push_back(make_vertex(mvt_pkg::SatMin, mvt_pkg::SatMin,
                                         mvt_pkg::SatMin, mvt_pkg::SatMin));
      vertex_queue.push_back(make_vertex(QOne, QMinusOne, mvt_pkg::SatMax, mvt_pkg::SatMin));
      vertex_queue.push_back(make_vertex(QLsb, QMinusLsb, QHalf, QMinusOneHalf));
      wait_idle();

      // largest positive coefficients: positive and negative saturation,
      // and opposite terms that cancel
      load_matrix(pattern_matrix(mvt_pkg::SatMax, mvt_pkg::SatMax), 1'b0);
      vertex_queue.push_back(make_vertex(mvt_pkg::SatMax, mvt_pkg::SatMax,
                                         mvt_pkg::SatMax, mvt_pkg::SatMax));
      vertex_queue.push_back(make_vertex(mvt_pkg::SatMin, mvt_pkg::SatMin,
                                         mvt_pkg::SatMin, mvt_pkg::SatMin));
      vertex_queue.push_back(make_vertex(mvt_pkg::SatMax, mvt_pkg::SatMin,
                                         mvt_pkg::SatMax, mvt_pkg::SatMin));
      vertex_queue.push_back(make_vertex(QOne, '0, '0, '0));
      wait_idle();

      // most negative coefficients: min times min overflows every product
      load_matrix(pattern_matrix(mvt_pkg::SatMin, mvt_pkg::SatMin), 1'b0);
      vertex_queue.push_back(make_vertex(mvt_pkg::SatMin, mvt_pkg::SatMin,
                                         mvt_pkg::SatMin, mvt_pkg::SatMin));
      vertex_queue.push_back(make_vertex(mvt_pkg::SatMax, mvt_pkg::SatMax,
                                         mvt_pkg::SatMax, mvt_pkg::SatMax));
      wait_idle();

      // one lsb coefficients: fraction dropped by floor, not truncation;
      // the unused index write must leave the matrix alone
      load_matrix(pattern_matrix(QLsb, QLsb), 1'b1);
      vertex_queue.push_back(make_vertex(QMinusLsb, '0, '0, '0));
      vertex_queue.push_back(make_vertex(QLsb, QLsb, QLsb, QLsb));
      vertex_queue.push_back(make_vertex(QMinusLsb, QMinusLsb, QLsb, '0));
      wait_idle();

      // alternating max and min columns
      load_matrix(pattern_matrix(mvt_pkg::SatMax, mvt_pkg::SatMin), 1'b1);
      vertex_queue.push_back(make_vertex(mvt_pkg::SatMax, mvt_pkg::SatMax,
                                         mvt_pkg::SatMax, mvt_pkg::SatMax));
      vertex_queue.push_back(make_vertex(mvt_pkg::SatMin, mvt_pkg::SatMin,
                                         mvt_pkg::SatMin, mvt_pkg::SatMin));
      vertex_queue.push_back(make_vertex(mvt_pkg::SatMax, mvt_pkg::SatMin,
                                         mvt_pkg::SatMax, mvt_pkg::SatMin));
      wait_idle();

      // random matrices, each with a long random vertex stream
      for (int phase = 0; phase < RandomPhases; phase++) begin
         foreach (m[i]) m[i] = {rand_coeff(), rand_coeff()};
         load_matrix(m, $urandom_range(0, 1));
         repeat (ItemsPerPhase) vertex_queue.push_back(rand_vertex());
         wait_idle();
      end

      if (error_count == 0) begin
         $display("tb_matrix_vector_transform_4x4_core passed");
      end else begin
         $display("tb_matrix_vector_transform_4x4_core failed");
      end
      $finish;
   end

endmodule
